### hdl/pcg32_ranged_integer_generator_macros.svh
// Assertion macros shared by the generator RTL.
`ifndef PCG32_RANGED_INTEGER_GENERATOR_MACROS_SVH
`define PCG32_RANGED_INTEGER_GENERATOR_MACROS_SVH

// Condition implies expression in the same cycle.
`define PCG_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// Condition implies expression in the following cycle.
`define PCG_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

### hdl/pcg32_pkg.sv
// Package with constants, types and the output permutation of the generator.
package pcg32_pkg;

  localparam logic [63:0] LcgMult     = 64'h5851_F42D_4C95_7F2D;
  localparam logic [62:0] ResetStream = 63'd1;
  localparam logic [63:0] ResetSeed   = 64'd0;
  // state after reseeding with seed 0 and increment 3: (3 + 0) * mult + 3
  localparam logic [63:0] ResetState  = 64'd3 * LcgMult + 64'd3;

  localparam int unsigned XsShift   = 18;
  localparam int unsigned XsTake    = 27;
  localparam int unsigned RotLsb    = 59;
  localparam int unsigned MulChunk  = 16;
  localparam int unsigned MulSteps  = 64 / MulChunk;

  // register indexes of the configuration port
  localparam logic CfgSeed   = 1'b0;
  localparam logic CfgStream = 1'b1;

  // request codes
  localparam logic OpRaw    = 1'b0;
  localparam logic OpRanged = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_MUL,
    ST_INC,
    ST_RANGE,
    ST_DIV,
    ST_SUM,
    ST_DONE
  } seq_state_t;

  // XSH-RR: xor-shift, take 32 bits, rotate right by the top five bits
  function automatic logic [31:0] xsh_rr(input logic [63:0] old);
    logic [63:0] mixed;
    logic [31:0] xs;
    logic [4:0]  rot;
    logic [63:0] doubled;
    mixed   = (old >> XsShift) ^ old;
    xs      = mixed[XsTake +: 32];
    rot     = old[RotLsb +: 5];
    doubled = {xs, xs} >> rot;
    return doubled[31:0];
  endfunction

endpackage

### hdl/pcg32_ranged_integer_generator.sv
// PCG32 XSH-RR generator with raw and bounded integer requests.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  cfg     | cfg_we               | cfg_index, cfg_data (seed / stream)
//  in      | in_valid / in_ready  | op, bound_a, bound_b
//  out     | out_valid / out_ready| value, range_fault, state_after
//
// Steps: a raw request runs the 4-step 16x64 multiplier and then adds the
// increment; a ranged request then also runs the 32-step restoring remainder
// loop, which it skips when the range wraps, and adds the low bound. All steps
// share the one 64-bit adder.
// A configuration write starts a reseed; in_ready stays low meanwhile.
// Reset is synchronous and loads the state of seed 0, stream 1 at once.
// A finished result waits in the output register; the next input beat is
// taken as soon as the sequencer has moved the result there.
module pcg32_ranged_integer_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic signed [63:0] bound_a,
  input  logic signed [63:0] bound_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] value,
  output logic               range_fault,
  output logic [63:0]        state_after
);

  `include "pcg32_ranged_integer_generator_macros.svh"

  pcg32_pkg::seq_state_t st, st_next;

  // configuration and generator state
  logic [63:0] seed;
  logic [62:0] stream;
  logic [63:0] lcg_state;
  logic [63:0] lcg_inc;

  // working registers
  logic        reseeding;
  logic        op_q;
  logic [4:0]  cnt;
  logic [63:0] mcand;
  logic [63:0] acc;
  logic [31:0] rbits;
  logic [63:0] lo;
  logic [63:0] hi;
  logic [63:0] span;
  logic [31:0] rem;
  logic [63:0] res_value;
  logic        res_fault;

  // shared adder and multiplier
  logic [63:0] add_a, add_b;
  logic        add_cin;
  logic [64:0] add_full;
  logic [63:0] add_sum;
  logic        add_carry;
  logic [15:0] mul_chunk;
  logic [79:0] mul_full;
  logic [63:0] mul_term;
  logic [32:0] rem_shift;

  logic in_beat;
  logic out_free;
  logic range_wrap;

  assign lcg_inc   = {stream, 1'b1};
  assign in_beat   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // one 16-bit slice of the multiplicand per step, weighted by its position
  always_comb begin
    unique case (cnt[1:0])
      2'd0:    mul_chunk = mcand[15:0];
      2'd1:    mul_chunk = mcand[31:16];
      2'd2:    mul_chunk = mcand[47:32];
      default: mul_chunk = mcand[63:48];
    endcase
  end

  assign mul_full = 80'(mul_chunk) * 80'(pcg32_pkg::LcgMult);
  assign mul_term = mul_full[63:0] << {cnt[1:0], 4'b0000};

  assign rem_shift = {rem, rbits[31]};

  assign add_full   = {1'b0, add_a} + {1'b0, add_b} + 65'(add_cin);
  assign add_sum    = add_full[63:0];
  assign add_carry  = add_full[64];
  assign range_wrap = &add_sum;

  // next state
  always_comb begin
    st_next = st;
    priority if (cfg_we) begin
      st_next = pcg32_pkg::ST_SEED;
    end else begin
      unique case (st)
        pcg32_pkg::ST_IDLE:  if (in_valid) st_next = pcg32_pkg::ST_MUL;
        pcg32_pkg::ST_SEED:  st_next = pcg32_pkg::ST_MUL;
        pcg32_pkg::ST_MUL: begin
          if (cnt[1:0] == 2'(pcg32_pkg::MulSteps - 1)) st_next = pcg32_pkg::ST_INC;
        end
        pcg32_pkg::ST_INC: begin
          if (reseeding) st_next = pcg32_pkg::ST_IDLE;
          else if (op_q == pcg32_pkg::OpRaw) st_next = pcg32_pkg::ST_DONE;
          else st_next = pcg32_pkg::ST_RANGE;
        end
        pcg32_pkg::ST_RANGE: begin
          st_next = range_wrap ? pcg32_pkg::ST_DONE : pcg32_pkg::ST_DIV;
        end
        pcg32_pkg::ST_DIV:   if (&cnt) st_next = pcg32_pkg::ST_SUM;
        pcg32_pkg::ST_SUM:   st_next = pcg32_pkg::ST_DONE;
        pcg32_pkg::ST_DONE:  if (out_free) st_next = pcg32_pkg::ST_IDLE;
        default:             st_next = pcg32_pkg::ST_IDLE;
      endcase
    end
  end

  // sequencer outputs: ready and the operands of the shared adder
  always_comb begin
    in_ready = (st == pcg32_pkg::ST_IDLE) && !cfg_we;
    add_a    = '0;
    add_b    = '0;
    add_cin  = 1'b0;
    unique case (st)
      pcg32_pkg::ST_SEED: begin
        // state 0 stepped once is just the increment; add the seed
        add_a = lcg_inc;
        add_b = seed;
      end
      pcg32_pkg::ST_MUL: begin
        add_a = acc;
        add_b = mul_term;
      end
      pcg32_pkg::ST_INC: begin
        add_a = acc;
        add_b = lcg_inc;
      end
      pcg32_pkg::ST_RANGE: begin
        // hi - lo; the range is this plus one
        add_a   = hi;
        add_b   = ~lo;
        add_cin = 1'b1;
      end
      pcg32_pkg::ST_DIV: begin
        // partial remainder minus range; carry out means it fits
        add_a = 64'(rem_shift);
        add_b = ~span;
      end
      pcg32_pkg::ST_SUM: begin
        add_a = lo;
        add_b = 64'(rem);
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= pcg32_pkg::ST_IDLE;
      seed        <= pcg32_pkg::ResetSeed;
      stream      <= pcg32_pkg::ResetStream;
      lcg_state   <= pcg32_pkg::ResetState;
      reseeding   <= 1'b0;
      out_valid   <= 1'b0;
      cnt         <= '0;
    end else begin
      st <= st_next;

      if (cfg_we) begin
        unique case (cfg_index)
          pcg32_pkg::CfgSeed:   seed   <= cfg_data;
          pcg32_pkg::CfgStream: stream <= cfg_data[62:0];
          default:              seed   <= seed;
        endcase
      end

      // raise the output beat as a result moves out, drop it once taken
      if (st == pcg32_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (st)
        pcg32_pkg::ST_IDLE: begin
          if (in_beat) begin
            op_q      <= op;
            mcand     <= lcg_state;
            acc       <= '0;
            cnt       <= '0;
            reseeding <= 1'b0;
            rbits     <= pcg32_pkg::xsh_rr(lcg_state);
            if (bound_a > bound_b) begin
              lo <= bound_b;
              hi <= bound_a;
            end else begin
              lo <= bound_a;
              hi <= bound_b;
            end
          end
        end
        pcg32_pkg::ST_SEED: begin
          mcand     <= add_sum;
          acc       <= '0;
          cnt       <= '0;
          reseeding <= 1'b1;
        end
        pcg32_pkg::ST_MUL: begin
          acc <= add_sum;
          cnt <= (cnt[1:0] == 2'(pcg32_pkg::MulSteps - 1)) ? '0 : cnt + 5'd1;
        end
        pcg32_pkg::ST_INC: begin
          lcg_state <= add_sum;
          reseeding <= 1'b0;
          res_value <= 64'(rbits);
          res_fault <= 1'b0;
        end
        pcg32_pkg::ST_RANGE: begin
          span      <= add_sum;
          rem       <= '0;
          cnt       <= '0;
          res_value <= lo;
          res_fault <= range_wrap;
        end
        pcg32_pkg::ST_DIV: begin
          // restoring remainder, one dividend bit a step
          rem   <= add_carry ? add_sum[31:0] : rem_shift[31:0];
          rbits <= rbits << 1;
          cnt   <= cnt + 5'd1;
        end
        pcg32_pkg::ST_SUM: begin
          res_value <= add_sum;
          res_fault <= 1'b0;
        end
        pcg32_pkg::ST_DONE: begin
          if (out_free) begin
            value       <= $signed(res_value);
            range_fault <= res_fault;
            state_after <= lcg_state;
          end
        end
        default: begin
          cnt <= '0;
        end
      endcase
    end
  end

  `PCG_ASSERT_NEXT(a_busy_after_beat, clk, rst, in_beat, !in_ready, "ready after an input beat")
  `PCG_ASSERT_NEXT(a_busy_after_cfg, clk, rst, cfg_we, !in_ready, "ready during reseed")
  `PCG_ASSERT_NOW(a_rem_in_range, clk, rst, st == pcg32_pkg::ST_DIV, 64'(rem) <= span, "remainder out of range")

endmodule

### verif/pcg32_ranged_integer_generator_tb.sv
// Self-checking testbench for the PCG32 ranged integer generator.
`timescale 1ns / 100ps

module pcg32_ranged_integer_generator_tb;

  localparam logic [63:0] MostNeg = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MostPos = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int unsigned ShownMismatches = 10;
  localparam int unsigned DrainCycles = 60;

  typedef struct {
    logic              op;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } request_t;

  typedef struct {
    logic signed [63:0] value;
    logic               fault;
    logic [63:0]        state_after;
  } draw_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_index = pcg32_pkg::CfgSeed;
  logic [63:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               op = pcg32_pkg::OpRaw;
  logic signed [63:0] bound_a = '0;
  logic signed [63:0] bound_b = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [63:0] value;
  logic               range_fault;
  logic [63:0]        state_after;

  pcg32_ranged_integer_generator uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .bound_a     (bound_a),
    .bound_b     (bound_b),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .range_fault (range_fault),
    .state_after (state_after)
  );

  // Requests waiting for the driver, and draws waiting for the output side.
  request_t pending_requests[$];
  draw_t    expected_draws[$];

  // Predicted generator: shadow registers plus the LCG state and increment.
  logic [63:0] seed_reg;
  logic [62:0] stream_reg;
  logic [63:0] gen_state;
  logic [63:0] gen_inc;

  // Idle percentages for each side, changed per phase by the stimulus.
  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 59;
  int unsigned mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reseed the standard way: state 0 stepped once is just the increment,
  // then add the seed and step again.
  function automatic void reseed_generator();
    gen_inc   = {stream_reg, 1'b1};
    gen_state = (gen_inc + seed_reg) * pcg32_pkg::LcgMult + gen_inc;
  endfunction

  function automatic void apply_register(input logic idx, input logic [63:0] data);
    if (idx == pcg32_pkg::CfgSeed) begin
      seed_reg = data;
    end else begin
      stream_reg = data[62:0]; // the top bit of the stream word is dropped
    end
    reseed_generator();
  endfunction

  // XSH-RR permutation of the pre-advance state.
  function automatic logic [31:0] permute_output(input logic [63:0] prev);
    logic [31:0] folded;
    logic [4:0]  amount;
    folded = 32'(((prev >> pcg32_pkg::XsShift) ^ prev) >> pcg32_pkg::XsTake);
    amount = prev[pcg32_pkg::RotLsb +: 5];
    return (folded >> amount) | (folded << (5'd0 - amount));
  endfunction

  // Advance the predicted state once and work out the draw for one request.
  function automatic draw_t compute_draw(input request_t req);
    draw_t       d;
    logic [63:0] prev;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] span;
    logic [31:0] raw;
    prev          = gen_state;
    gen_state     = prev * pcg32_pkg::LcgMult + gen_inc;
    raw           = permute_output(prev);
    d.fault       = 1'b0;
    d.state_after = gen_state;
    if (req.op == pcg32_pkg::OpRaw) begin
      d.value = {32'd0, raw};
    end else begin
      lo = req.a;
      hi = req.b;
      if (req.a > req.b) begin
        lo = req.b;
        hi = req.a;
      end
      span = hi - lo + 64'd1;
      // full signed span wraps the range to zero: flag it, return the low bound
      if (span == 64'd0) begin
        d.fault = 1'b1;
        d.value = lo;
      end else begin
        d.value = lo + ({32'd0, raw} % span);
      end
    end
    return d;
  endfunction

  function automatic request_t random_request();
    request_t    r;
    logic [63:0] base;
    logic [63:0] span;
    r.op = $urandom_range(1) ? pcg32_pkg::OpRanged : pcg32_pkg::OpRaw;
    base = {$urandom, $urandom};
    case ($urandom_range(15))
      0, 1, 2: begin
        r.a = base;
        r.b = {$urandom, $urandom};
      end
      3, 4, 5: begin
        r.a = base;
        r.b = base + 64'($urandom_range(1000));
      end
      6, 7, 8: begin
        span = 64'd1 << $urandom_range(63);
        r.a  = base;
        r.b  = base + span - 64'd1;
      end
      9, 10: begin
        r.a = $signed(32'($urandom));
        r.b = r.a + 64'($urandom);
      end
      11: begin
        r.a = base;
        r.b = base;
      end
      12, 13: begin
        case ($urandom_range(3))
          0: r.a = MostNeg;
          1: r.a = MostPos;
          2: r.a = '0;
          default: r.a = AllOnes;
        endcase
        r.b = $urandom_range(1) ? base : (MostPos - 64'($urandom_range(3)));
      end
      14: begin
        r.a = MostNeg;
        r.b = MostPos;
      end
      default: begin
        r.a = MostNeg + 64'($urandom_range(2));
        r.b = MostPos - 64'($urandom_range(2));
      end
    endcase
    // put the bounds either way round
    if ($urandom_range(1)) begin
      base = r.a;
      r.a  = r.b;
      r.b  = base;
    end
    return r;
  endfunction

  task automatic queue_request(input logic o, input logic [63:0] a, input logic [63:0] b);
    request_t r;
    r.op = o;
    r.a  = a;
    r.b  = b;
    pending_requests.push_back(r);
  endtask

  // Poll on the falling edge so the clocked blocks have settled.
  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || expected_draws.size() != 0)
      @(negedge clk);
  endtask

  // Write one register; the block is idle here, so update the prediction first.
  task automatic write_register(input logic idx, input logic [63:0] data);
    @(negedge clk);
    apply_register(idx, data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_batch(input int unsigned count);
    @(negedge clk);
    repeat (count) pending_requests.push_back(random_request());
    wait_drained();
  endtask

  // Driver: log the accepted beat against the prediction, then present the
  // next request or drop valid. Valid is only assigned once per edge.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_draws.push_back(compute_draw('{op, bound_a, bound_b}));
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          op       <= pending_requests[0].op;
          bound_a  <= pending_requests[0].a;
          bound_b  <= pending_requests[0].b;
          pending_requests.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction and
  // stall the output side at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_draws.size() == 0) begin
          mismatches++;
          if (mismatches <= ShownMismatches)
            $display("unexpected result beat: value %h fault %b state %h",
                     value, range_fault, state_after);
        end else begin
          if (value !== expected_draws[0].value || range_fault !== expected_draws[0].fault ||
              state_after !== expected_draws[0].state_after) begin
            mismatches++;
            if (mismatches <= ShownMismatches)
              $display("mismatch: exp value %h fault %b state %h, got %h fault %b state %h",
                       expected_draws[0].value, expected_draws[0].fault,
                       expected_draws[0].state_after, value, range_fault, state_after);
          end
          expected_draws.pop_front();
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("pcg32_ranged_integer_generator verification failed");
    $finish;
  end

  initial begin
    seed_reg   = pcg32_pkg::ResetSeed;
    stream_reg = pcg32_pkg::ResetStream;
    reseed_generator();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset seeding: raw draws ignore the bounds,
    // reversed bounds swap, the full signed span faults, narrow and wide
    // spans either side of it do not.
    @(negedge clk);
    queue_request(pcg32_pkg::OpRaw,    MostNeg, MostPos);
    queue_request(pcg32_pkg::OpRaw,    AllOnes, '0);
    queue_request(pcg32_pkg::OpRanged, MostNeg, MostPos);
    queue_request(pcg32_pkg::OpRanged, MostPos, MostNeg);
    queue_request(pcg32_pkg::OpRanged, 64'sd10, -64'sd5);
    queue_request(pcg32_pkg::OpRanged, 64'sd42, 64'sd42);
    queue_request(pcg32_pkg::OpRanged, MostNeg, MostNeg);
    queue_request(pcg32_pkg::OpRanged, MostPos, MostPos);
    queue_request(pcg32_pkg::OpRanged, '0, MostPos);
    queue_request(pcg32_pkg::OpRanged, MostNeg, MostPos - 64'd1);
    queue_request(pcg32_pkg::OpRanged, MostPos, MostNeg + 64'd1);
    queue_request(pcg32_pkg::OpRanged, AllOnes, '0);
    queue_request(pcg32_pkg::OpRanged, MostNeg, MostNeg + 64'd1);
    queue_request(pcg32_pkg::OpRanged, MostPos - 64'd1, MostPos);
    queue_request(pcg32_pkg::OpRanged, '0, 64'd9);
    queue_request(pcg32_pkg::OpRanged, '0, 64'h0000_0000_FFFF_FFFF);
    queue_request(pcg32_pkg::OpRanged, 64'h0000_0000_FFFF_FFFE, '0);
    queue_request(pcg32_pkg::OpRaw,    '0, '0);
    wait_drained();

    // Random phases, one register write between each; idling moves from
    // slow sender / slow receiver, to the reverse, to none at all.
    for (int k = 0; k < 8; k++) begin
      if (k == 3) begin
        send_idle_pct = 59;
        recv_idle_pct = 37;
      end else if (k == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (k)
        0: write_register(pcg32_pkg::CfgSeed, AllOnes);
        1: write_register(pcg32_pkg::CfgStream, '0);
        2: write_register(pcg32_pkg::CfgStream, AllOnes);
        3: write_register(pcg32_pkg::CfgSeed, '0);
        4: write_register(pcg32_pkg::CfgSeed, {$urandom, $urandom});
        5: write_register(pcg32_pkg::CfgStream, {$urandom, $urandom});
        6: write_register(pcg32_pkg::CfgStream, 64'd1);
        default: write_register(pcg32_pkg::CfgSeed, {$urandom, $urandom});
      endcase
      run_batch(190);
    end

    // Give any stray result beat time to show up.
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("pcg32_ranged_integer_generator verification clean");
    end else begin
      $display("pcg32_ranged_integer_generator verification failed");
    end
    $finish;
  end

endmodule
